// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

// ===== src/tmwf_pkg.sv =====
// Shared types and constants of the trimmed-mean window filter.
package tmwf_pkg;

	localparam int DATA_W = 16;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/trimmed_mean_window_filter_core.sv =====
// Trimmed-mean sliding window filter: history memory, rank sequencer and divider control.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   input    | in_valid / in_stall  | sample
//   output   | out_valid / out_stall| filtered, empty_res
//
// One word is worked on at a time; in_stall is high from acceptance until the result
// moves into the output register. For a non-empty history the wait for the next
// acceptance is set by the single read port of the history memory and the bit-serial
// divider on the SW-bit sum (SW = 20 at N = HISTORY_DEPTH = 8). The result shows in the
// same cycle in which the next word can be accepted. History needs no clearing pass
// after reset: the fill count bounds every read. A stalled output holds its word while
// the next one is worked on.
module trimmed_mean_window_filter_core #(
	parameter int HISTORY_DEPTH = 8,
	parameter int KEEP_COUNT    = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [tmwf_pkg::DATA_W-1:0]  sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tmwf_pkg::DATA_W-1:0]  filtered,
	output logic                                empty_res
);

	localparam int DW   = tmwf_pkg::DATA_W;
	localparam int AW   = $clog2(HISTORY_DEPTH);
	localparam int CW   = $clog2(HISTORY_DEPTH + 1);
	localparam int SW   = DW + $clog2(HISTORY_DEPTH) + 1;
	localparam int KEFF = (KEEP_COUNT > HISTORY_DEPTH) ? HISTORY_DEPTH : KEEP_COUNT;
	localparam int OFF  = (HISTORY_DEPTH - KEFF) / 2;

	localparam logic [CW-1:0] FULL   = CW'(HISTORY_DEPTH);
	localparam logic [CW-1:0] KEEP_C = CW'(KEFF);
	localparam logic [CW-1:0] RANK_LO = CW'(OFF);
	localparam logic [CW-1:0] RANK_HI = CW'(OFF + KEFF);
	localparam logic [AW-1:0] LAST_A = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SUM   = 6'b000010,
		ST_LOADI = 6'b000100,
		ST_CMP   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                 state_q;
	logic signed [DW-1:0]   hist_mem [HISTORY_DEPTH];
	logic signed [DW-1:0]   rd_s1;
	logic        [AW-1:0]   raddr;
	logic        [AW-1:0]   wp_q;
	logic        [CW-1:0]   fill_q;
	logic signed [DW-1:0]   last_q;
	logic        [CW-1:0]   idx_q;
	logic        [AW-1:0]   i_q;
	logic        [CW-1:0]   rank_q;
	logic signed [DW-1:0]   vi_q;
	logic signed [SW-1:0]   acc_q;
	logic signed [DW-1:0]   res_q;
	logic                   empty_q;
	logic                   div_start_q;
	logic                   out_valid_q;
	logic signed [DW-1:0]   filtered_q;
	logic                   empty_res_q;

	logic                   accept;
	logic                   changed;
	logic        [CW-1:0]   fill_nx;
	logic        [CW-1:0]   jprev;
	logic                   below;
	logic        [CW-1:0]   rank_nx;
	logic                   keep;
	logic        [CW-1:0]   div_den;
	logic        [SW-1:0]   div_quo;
	tmwf_pkg::div_stat_t    div_stat;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign changed  = (sample != last_q);
	assign fill_nx  = (changed && (fill_q != FULL)) ? fill_q + 1'b1 : fill_q;

	// Element j ranks below element i if smaller, or equal and at a lower address
	assign jprev   = idx_q - 1'b1;
	assign below   = (rd_s1 < vi_q) || ((rd_s1 == vi_q) && (jprev < CW'(i_q)));
	assign rank_nx = rank_q + CW'(below);
	assign keep    = (rank_nx >= RANK_LO) && (rank_nx < RANK_HI);

	assign div_den = (fill_q == FULL) ? KEEP_C : fill_q;

	always_comb begin
		priority if ((state_q == ST_CMP) && (idx_q == FULL)) begin
			raddr = i_q + 1'b1;
		end else if ((state_q == ST_CMP) || (state_q == ST_SUM)) begin
			raddr = idx_q[AW-1:0];
		end else begin
			raddr = i_q;
		end
	end

	// Writes happen only on acceptance; reads follow in later cycles, so no overlap
	always_ff @(posedge clk) begin
		if (accept && changed) begin
			hist_mem[wp_q] <= sample;
		end
		rd_s1 <= hist_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			last_q      <= '0;
			idx_q       <= '0;
			i_q         <= '0;
			rank_q      <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (changed) begin
							wp_q   <= (wp_q == LAST_A) ? '0 : wp_q + 1'b1;
							last_q <= sample;
						end
						fill_q <= fill_nx;
						idx_q  <= '0;
						i_q    <= '0;
						priority if (fill_nx == '0) begin
							state_q <= ST_DONE;
						end else if (fill_nx == FULL) begin
							state_q <= ST_LOADI;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (idx_q == fill_q) begin
						state_q     <= ST_DIV;
						div_start_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LOADI: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (idx_q == '0) begin
						rank_q <= '0;
						idx_q  <= idx_q + 1'b1;
					end else if (idx_q == FULL) begin
						idx_q <= '0;
						if (i_q == LAST_A) begin
							state_q     <= ST_DIV;
							div_start_q <= 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						rank_q <= rank_nx;
						idx_q  <= idx_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Load a new word into the output register or drop the one taken
			if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q   <= '0;
			res_q   <= '0;
			empty_q <= (fill_nx == '0);
		end
		if ((state_q == ST_SUM) && (idx_q != '0)) begin
			acc_q <= acc_q + SW'(rd_s1);
		end
		if ((state_q == ST_CMP) && (idx_q == '0)) begin
			vi_q <= rd_s1;
		end
		if ((state_q == ST_CMP) && (idx_q == FULL) && keep) begin
			acc_q <= acc_q + SW'(vi_q);
		end
		if ((state_q == ST_DIV) && div_stat.done) begin
			res_q   <= div_quo[DW-1:0];
			empty_q <= 1'b0;
		end
		if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
			filtered_q  <= res_q;
			empty_res_q <= empty_q;
		end
	end

	tmwf_div #(
		.NUM_W (SW),
		.DEN_W (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (acc_q),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign empty_res = empty_res_q;

endmodule

// ===== src/tmwf_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module tmwf_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic        [NUM_W-1:0] quo,
	output tmwf_pkg::div_stat_t     stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_df;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign rem_df = rem_sh - {1'b0, den_q};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: work on the magnitude, fix the sign at the end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			neg_q <= num[NUM_W-1];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? rem_df[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quo       = neg_q ? NUM_W'(-quo_q) : quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== src/tmwf_checker.sv =====
// Port-level checker for the trimmed-mean window filter, bound to the top level.
`include "assert_macros.svh"

module tmwf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [tmwf_pkg::DATA_W-1:0] filtered,
	input logic                               empty_res
);

	// One word at a time: an accepted word stalls the input next cycle
	`ASSERT_NEXT(a_accept_stalls, clk, arst_n, in_valid && !in_stall, in_stall)

	// An empty history always reports zero
	`ASSERT_SAME(a_empty_zero, clk, arst_n, out_valid && empty_res, filtered == '0)

	// A new result only appears after a word was being worked on
	`ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(out_valid), $past(in_stall))

	// Hold a stalled result
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(filtered) && $stable(empty_res))

endmodule

bind trimmed_mean_window_filter_core tmwf_checker u_tmwf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.filtered  (filtered),
	.empty_res (empty_res)
);

// ===== sim/trimmed_mean_window_filter_core_tb.sv =====
// Self-checking testbench for the trimmed-mean sliding window filter core.
`timescale 1ns / 100ps

typedef struct {
	logic signed [15:0] filtered;
	logic               empty_res;
} filter_word_t;

class trim_mean_scoreboard #(int DEPTH = 8, int KEEP = 4);
	localparam int EFF_KEEP = (KEEP > DEPTH) ? DEPTH : KEEP;
	localparam int TRIM_LOW = (DEPTH - EFF_KEEP) / 2;

	logic signed [15:0] window [DEPTH];
	int                 fill;
	logic signed [15:0] last_taken;
	filter_word_t       expected_means [$];
	int                 errors;

	function new();
		foreach (window[i])
			window[i] = '0;
		fill = 0;
		last_taken = '0;
		errors = 0;
	endfunction

	// Update the window with an accepted word and queue the mean it produces.
	function void note_sample(logic signed [15:0] s);
		int           total;
		int           ranked [DEPTH];
		int           v;
		int           j;
		filter_word_t w;
		total = 0;
		if (s != last_taken) begin
			for (int i = DEPTH - 1; i > 0; i--)
				window[i] = window[i - 1];
			window[0] = s;
			if (fill < DEPTH)
				fill++;
			last_taken = s;
		end
		if (fill == 0) begin
			w.filtered = '0;
			w.empty_res = 1'b1;
		end else if (fill < DEPTH) begin
			for (int i = 0; i < DEPTH; i++)
				total += int'(window[i]);
			w.filtered = 16'(total / fill);
			w.empty_res = 1'b0;
		end else begin
			for (int i = 0; i < DEPTH; i++)
				ranked[i] = int'(window[i]);
			for (int i = 1; i < DEPTH; i++) begin
				v = ranked[i];
				j = i - 1;
				while (j >= 0 && ranked[j] > v) begin
					ranked[j + 1] = ranked[j];
					j--;
				end
				ranked[j + 1] = v;
			end
			for (int i = TRIM_LOW; i < TRIM_LOW + EFF_KEEP; i++)
				total += ranked[i];
			w.filtered = 16'(total / EFF_KEEP);
			w.empty_res = 1'b0;
		end
		expected_means.push_back(w);
	endfunction

	function void check_result(logic signed [15:0] filtered, logic empty_res);
		filter_word_t w;
		if (expected_means.size() == 0) begin
			$error("unexpected result word: filtered=%0d empty_res=%0b", filtered, empty_res);
			errors++;
			return;
		end
		w = expected_means.pop_front();
		if (filtered !== w.filtered) begin
			$error("filtered: expected %0d, got %0d", w.filtered, filtered);
			errors++;
		end
		if (empty_res !== w.empty_res) begin
			$error("empty_res: expected %0b, got %0b", w.empty_res, empty_res);
			errors++;
		end
	endfunction

	function int pending();
		return expected_means.size();
	endfunction
endclass

module trimmed_mean_window_filter_core_tb;
	localparam int HISTORY_DEPTH = 8;
	localparam int KEEP_COUNT    = 4;
	localparam int RANDOM_WORDS  = 450;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] sample;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] filtered;
	logic               empty_res;

	trim_mean_scoreboard #(HISTORY_DEPTH, KEEP_COUNT) sb;
	int                 send_calm;
	int                 recv_calm;
	logic signed [15:0] last_sent;

	trimmed_mean_window_filter_core #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.KEEP_COUNT   (KEEP_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered (filtered),
		.empty_res(empty_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw a random idle gap, with occasional runs of back-to-back words.
	function automatic int draw_wait(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic drive_sample(input logic signed [15:0] s);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s);
		last_sent = s;
	endtask

	// Hold off the sender until every queued mean has come back.
	task automatic drain_pause();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic signed [15:0] pick_sample();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 20)
			return last_sent;
		if (kind < 30) begin
			case ($urandom_range(0, 4))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh0000;
				3: return -16'sd1;
				default: return 16'sd1;
			endcase
		end
		if (kind < 65)
			return 16'($signed($urandom_range(0, 600)) - 300);
		return 16'($urandom());
	endfunction

	task automatic run_receiver();
		int gap;
		forever begin
			gap = draw_wait(recv_calm);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(filtered, empty_res);
		end
	endtask

	initial begin
		#5_000_000;
		$display("** trimmed_mean_window_filter_core: FAILED **");
		$finish;
	end

	initial begin
		logic signed [15:0] directed [$];
		sb = new();
		send_calm = 0;
		recv_calm = 0;
		last_sent = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		out_stall <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		fork
			run_receiver();
		join_none

		// Empty history, repeats, extremes, negative truncation, fill to full, odd mixes.
		directed = '{16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sd1,
			-16'sd7, 16'sd5, 16'sh8000, 16'sh7FFF, 16'sd12345, 16'sh8000, 16'sh8000,
			16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, -16'sd3, 16'sd2,
			-16'sd1, 16'sh7FFF, 16'sh7FFF};
		foreach (directed[i])
			drive_sample(directed[i]);
		drain_pause();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			drive_sample(pick_sample());
			if (n == RANDOM_WORDS / 2)
				drain_pause();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("** trimmed_mean_window_filter_core: PASSED **");
		else
			$display("** trimmed_mean_window_filter_core: FAILED **");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/tmwf_pkg.sv
src/tmwf_div.sv
src/trimmed_mean_window_filter_core.sv
src/tmwf_checker.sv
sim/trimmed_mean_window_filter_core_tb.sv
